[hw/rtl/c8ic_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8ic_pkg
// Shared constants and function codes of the chip-8 instruction core.
// ----------------------------------------------------------------------------
package c8ic_pkg;

  localparam int MEM_DEPTH     = 4096;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_PIXELS = 2048;
  localparam int STACK_DEPTH   = 16;
  localparam int FB_ROWS       = SCREEN_PIXELS / SCREEN_WIDTH;

  localparam logic [11:0] START_ADDRESS = 12'h200;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_STEP = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SE   = 4'h3;
  localparam logic [3:0] GRP_SNE  = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LD   = 4'h6;
  localparam logic [3:0] GRP_ADD  = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDI  = 4'hA;
  localparam logic [3:0] GRP_JPV0 = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [3:0] ALU_LD  = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KK_SKP  = 8'h9E;
  localparam logic [7:0] KK_SKNP = 8'hA1;
  localparam logic [7:0] KK_LDDT = 8'h07;
  localparam logic [7:0] KK_WKEY = 8'h0A;
  localparam logic [7:0] KK_SDT  = 8'h15;
  localparam logic [7:0] KK_SST  = 8'h18;
  localparam logic [7:0] KK_ADDI = 8'h1E;
  localparam logic [7:0] KK_FONT = 8'h29;
  localparam logic [7:0] KK_BCD  = 8'h33;
  localparam logic [7:0] KK_STR  = 8'h55;
  localparam logic [7:0] KK_LDR  = 8'h65;

  localparam logic [3:0] REG_VF = 4'hF;
  localparam logic [3:0] REG_V0 = 4'h0;

endpackage
`default_nettype wire

[hw/rtl/chip8_instruction_core_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_instruction_core_top
// Chip-8 core with program memory, frame buffer, registers, stack and timers.
// ----------------------------------------------------------------------------
// One transaction at a time. A plain instruction fetches two bytes from the
// single-port program memory and makes two register-file reads; instructions
// that write two registers, BCD and FX55/FX65 take further steps, and a sprite
// draw works row by row through the pixel-serial read-modify-write of the
// 64-bit-row frame buffer, with an extra step per set pixel on screen. The
// frame buffer rows carry valid bits, so reset and screen clear need no pass
// over the rows. A new transaction is taken while a result still waits at the
// output register.
module chip8_instruction_core_top (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_func,
  input  wire logic [11:0]           in_addr,
  input  wire logic [7:0]            in_data,
  input  wire logic [15:0]           in_keys,
  input  wire logic [7:0]            in_random,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [11:0]                out_prog_counter,
  output logic                       out_pixel,
  output logic                       out_draw_flag,
  output logic                       out_sound_on,
  output logic                       out_waiting_key,
  output logic                       out_bad_opcode
);
  import c8ic_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_FETCH0 = 18'h00002,
    S_FETCH1 = 18'h00004,
    S_FETCH2 = 18'h00008,
    S_RDY    = 18'h00010,
    S_EXEC   = 18'h00020,
    S_WRX    = 18'h00040,
    S_DMRD   = 18'h00080,
    S_DBITS  = 18'h00100,
    S_DPIX   = 18'h00200,
    S_DPWR   = 18'h00400,
    S_BCD    = 18'h00800,
    S_STRD   = 18'h01000,
    S_STWR   = 18'h02000,
    S_LDRD   = 18'h04000,
    S_LDWR   = 18'h08000,
    S_PIX    = 18'h10000,
    S_DONE   = 18'h20000
  } state_t;

  // memories
  logic [7:0]  mmem [MEM_DEPTH];
  logic [7:0]  mq_r;
  logic        m_we;
  logic [11:0] m_addr;
  logic [7:0]  m_wd;

  logic [7:0]  rmem [16];
  logic [15:0] rvalid_r;
  logic [7:0]  rq_r;
  logic        r_we;
  logic [3:0]  r_addr;
  logic [7:0]  r_wd;

  logic [SCREEN_WIDTH-1:0] fmem [FB_ROWS];
  logic [FB_ROWS-1:0]      fvalid_r;
  logic [SCREEN_WIDTH-1:0] fq_r;
  logic                    f_we;
  logic                    f_clr;
  logic [4:0]              f_row;
  logic [SCREEN_WIDTH-1:0] f_wd;

  // control and architectural state
  state_t      state_r, state_nxt;
  logic [1:0]  func_r, func_nxt;
  logic [11:0] addr_r, addr_nxt;
  logic [15:0] keys_r, keys_nxt;
  logic [7:0]  rnd_r, rnd_nxt;
  logic [15:0] op_r, op_nxt;
  logic [7:0]  vx_r, vx_nxt;
  logic [7:0]  vy_r, vy_nxt;
  logic [7:0]  xval_r, xval_nxt;
  logic [11:0] pc_r, pc_nxt;
  logic [15:0] i_r, i_nxt;
  logic [3:0]  sp_r, sp_nxt;
  logic [7:0]  dt_r, dt_nxt;
  logic [7:0]  st_r, st_nxt;
  logic [11:0] stack_r [STACK_DEPTH];
  logic        stk_we;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [3:0]  col_r, col_nxt;
  logic [7:0]  bits_r, bits_nxt;
  logic        hit_r, hit_nxt;
  logic        tick_r, tick_nxt;
  logic        pix_r, pix_nxt;
  logic        draw_r, draw_nxt;
  logic        wait_r, wait_nxt;
  logic        bad_r, bad_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [11:0] out_pc_r, out_pc_nxt;
  logic        out_pix_r, out_pix_nxt;
  logic        out_draw_r, out_draw_nxt;
  logic        out_snd_r, out_snd_nxt;
  logic        out_wait_r, out_wait_nxt;
  logic        out_bad_r, out_bad_nxt;

  // decode helpers
  logic [3:0]  op_x, op_y, op_n;
  logic [7:0]  op_kk;
  logic [11:0] op_nnn;
  logic [11:0] pc_p2, pc_p4;
  logic [8:0]  add9;
  logic [16:0] sum_i;
  logic [3:0]  key_lo;
  logic        key_hit;
  logic [3:0]  sp_dec;
  logic [8:0]  yrow;
  logic [15:0] paddr;
  logic        pix_on;
  logic [1:0]  bcd_h;
  logic [7:0]  bcd_rem;
  logic [15:0] bcd_mul;
  logic [3:0]  bcd_t;
  logic [7:0]  bcd_o;
  logic [7:0]  st_tick;
  logic [7:0]  dt_tick;
  logic        in_acc;
  logic        out_free;

  assign op_x   = op_r[11:8];
  assign op_y   = op_r[7:4];
  assign op_n   = op_r[3:0];
  assign op_kk  = op_r[7:0];
  assign op_nnn = op_r[11:0];
  assign pc_p2  = pc_r + 12'd2;
  assign pc_p4  = pc_r + 12'd4;
  assign add9   = {1'b0, vx_r} + {1'b0, vy_r};
  assign sum_i  = {1'b0, i_r} + {9'b0, vx_r};
  assign sp_dec = sp_r - 4'd1;
  assign key_hit = (vx_r[7:4] == 4'd0) && keys_r[vx_r[3:0]];
  assign yrow   = {1'b0, vy_r} + {5'b0, cnt_r};
  assign paddr  = {1'b0, yrow, 6'b0} + {8'b0, vx_r} + {12'b0, col_r};
  assign pix_on = bits_r[3'd7 - col_r[2:0]] && (paddr[15:11] == 5'd0);

  // bcd: hundreds by compare, tens by reciprocal multiply of the remainder
  always_comb begin
    if (vx_r >= 8'd200) begin
      bcd_h   = 2'd2;
      bcd_rem = vx_r - 8'd200;
    end else if (vx_r >= 8'd100) begin
      bcd_h   = 2'd1;
      bcd_rem = vx_r - 8'd100;
    end else begin
      bcd_h   = 2'd0;
      bcd_rem = vx_r;
    end
    bcd_mul = {8'b0, bcd_rem} * 16'd205;
    bcd_t   = bcd_mul[14:11];
    bcd_o   = bcd_rem - ({4'b0, bcd_t} * 8'd10);
  end

  // lowest pressed key
  always_comb begin
    key_lo = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_r[k]) key_lo = 4'(k);
    end
  end

  assign dt_tick  = (tick_r && dt_r != 8'd0) ? dt_r - 8'd1 : dt_r;
  assign st_tick  = (tick_r && st_r != 8'd0) ? st_r - 8'd1 : st_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    addr_nxt  = addr_r;
    keys_nxt  = keys_r;
    rnd_nxt   = rnd_r;
    op_nxt    = op_r;
    vx_nxt    = vx_r;
    vy_nxt    = vy_r;
    xval_nxt  = xval_r;
    pc_nxt    = pc_r;
    i_nxt     = i_r;
    sp_nxt    = sp_r;
    dt_nxt    = dt_r;
    st_nxt    = st_r;
    stk_we    = 1'b0;
    cnt_nxt   = cnt_r;
    col_nxt   = col_r;
    bits_nxt  = bits_r;
    hit_nxt   = hit_r;
    tick_nxt  = tick_r;
    pix_nxt   = pix_r;
    draw_nxt  = draw_r;
    wait_nxt  = wait_r;
    bad_nxt   = bad_r;
    m_we   = 1'b0;
    m_addr = pc_r;
    m_wd   = in_data;
    r_we   = 1'b0;
    r_addr = op_x;
    r_wd   = xval_r;
    f_we   = 1'b0;
    f_clr  = 1'b0;
    f_row  = paddr[10:6];
    f_wd   = fq_r ^ (64'd1 << paddr[5:0]);
    out_valid_nxt = out_valid_r && out_stall;
    out_pc_nxt    = out_pc_r;
    out_pix_nxt   = out_pix_r;
    out_draw_nxt  = out_draw_r;
    out_snd_nxt   = out_snd_r;
    out_wait_nxt  = out_wait_r;
    out_bad_nxt   = out_bad_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func;
          addr_nxt = in_addr;
          keys_nxt = in_keys;
          rnd_nxt  = in_random;
          pix_nxt  = 1'b0;
          draw_nxt = 1'b0;
          wait_nxt = 1'b0;
          bad_nxt  = 1'b0;
          tick_nxt = 1'b0;
          case (func_t'(in_func))
            FUNC_LOAD: begin
              m_we      = 1'b1;
              m_addr    = in_addr;
              state_nxt = S_DONE;
            end
            FUNC_STEP: begin
              m_addr    = pc_r;
              state_nxt = S_FETCH0;
            end
            FUNC_READ: begin
              f_row     = in_addr[10:6];
              state_nxt = S_PIX;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_PIX: begin
        pix_nxt   = !addr_r[11] && fq_r[addr_r[5:0]];
        state_nxt = S_DONE;
      end
      S_FETCH0: begin
        op_nxt    = {mq_r, op_r[7:0]};
        m_addr    = pc_r + 12'd1;
        state_nxt = S_FETCH1;
      end
      S_FETCH1: begin
        op_nxt    = {op_r[15:8], mq_r};
        r_addr    = op_r[11:8];
        state_nxt = S_FETCH2;
      end
      S_FETCH2: begin
        vx_nxt    = rq_r;
        r_addr    = (op_r[15:12] == GRP_JPV0) ? REG_V0 : op_y;
        state_nxt = S_RDY;
      end
      S_RDY: begin
        vy_nxt    = rq_r;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        pc_nxt    = pc_p2;
        tick_nxt  = 1'b1;
        state_nxt = S_DONE;
        case (op_r[15:12])
          GRP_SYS: begin
            if (op_r == OP_CLS) begin
              f_clr    = 1'b1;
              draw_nxt = 1'b1;
            end else if (op_r == OP_RET) begin
              sp_nxt = sp_dec;
              pc_nxt = stack_r[sp_dec] + 12'd2;
            end else begin
              bad_nxt = 1'b1;
              pc_nxt  = pc_r;
            end
          end
          GRP_JP: pc_nxt = op_nnn;
          GRP_CALL: begin
            stk_we = 1'b1;
            sp_nxt = sp_r + 4'd1;
            pc_nxt = op_nnn;
          end
          GRP_SE:   if (vx_r == op_kk) pc_nxt = pc_p4;
          GRP_SNE:  if (vx_r != op_kk) pc_nxt = pc_p4;
          GRP_SER:  if (vx_r == vy_r) pc_nxt = pc_p4;
          GRP_SNER: if (vx_r != vy_r) pc_nxt = pc_p4;
          GRP_LD: begin
            r_we = 1'b1;
            r_wd = op_kk;
          end
          GRP_ADD: begin
            r_we = 1'b1;
            r_wd = vx_r + op_kk;
          end
          GRP_ALU: begin
            r_addr = REG_VF;
            case (op_n)
              ALU_LD:  begin r_addr = op_x; r_we = 1'b1; r_wd = vy_r; end
              ALU_OR:  begin r_addr = op_x; r_we = 1'b1; r_wd = vx_r | vy_r; end
              ALU_AND: begin r_addr = op_x; r_we = 1'b1; r_wd = vx_r & vy_r; end
              ALU_XOR: begin r_addr = op_x; r_we = 1'b1; r_wd = vx_r ^ vy_r; end
              ALU_ADD: begin
                r_we = 1'b1; r_wd = {7'b0, add9[8]};
                xval_nxt = add9[7:0]; state_nxt = S_WRX;
              end
              ALU_SUB: begin
                r_we = 1'b1; r_wd = {7'b0, !(vy_r > vx_r)};
                xval_nxt = vx_r - vy_r; state_nxt = S_WRX;
              end
              ALU_SHR: begin
                r_we = 1'b1; r_wd = {7'b0, vx_r[0]};
                xval_nxt = {1'b0, vx_r[7:1]}; state_nxt = S_WRX;
              end
              ALU_SBN: begin
                r_we = 1'b1; r_wd = {7'b0, !(vx_r > vy_r)};
                xval_nxt = vy_r - vx_r; state_nxt = S_WRX;
              end
              ALU_SHL: begin
                r_we = 1'b1; r_wd = {7'b0, vx_r[7]};
                xval_nxt = {vx_r[6:0], 1'b0}; state_nxt = S_WRX;
              end
              default: begin
                bad_nxt = 1'b1;
                pc_nxt  = pc_r;
              end
            endcase
          end
          GRP_LDI:  i_nxt = {4'b0, op_nnn};
          GRP_JPV0: pc_nxt = {4'b0, vy_r} + op_nnn;
          GRP_RND: begin
            r_we = 1'b1;
            r_wd = rnd_r & op_kk;
          end
          GRP_DRW: begin
            draw_nxt  = 1'b1;
            hit_nxt   = 1'b0;
            cnt_nxt   = 4'd0;
            state_nxt = S_DMRD;
          end
          GRP_KEY: begin
            if (op_kk == KK_SKP) begin
              if (key_hit) pc_nxt = pc_p4;
            end else if (op_kk == KK_SKNP) begin
              if (!key_hit) pc_nxt = pc_p4;
            end else begin
              bad_nxt = 1'b1;
              pc_nxt  = pc_r;
            end
          end
          default: begin
            case (op_kk)
              KK_LDDT: begin r_we = 1'b1; r_wd = dt_r; end
              KK_WKEY: begin
                if (keys_r == 16'd0) begin
                  wait_nxt = 1'b1;
                  pc_nxt   = pc_r;
                  tick_nxt = 1'b0;
                end else begin
                  r_we = 1'b1;
                  r_wd = {4'b0, key_lo};
                end
              end
              KK_SDT: dt_nxt = vx_r;
              KK_SST: st_nxt = vx_r;
              KK_ADDI: begin
                r_addr = REG_VF;
                r_we   = 1'b1;
                r_wd   = {7'b0, (sum_i > 17'hFFF)};
                i_nxt  = sum_i[15:0];
              end
              KK_FONT: i_nxt = {8'b0, vx_r} * 16'd5;
              KK_BCD: begin
                cnt_nxt   = 4'd0;
                state_nxt = S_BCD;
              end
              KK_STR: begin
                cnt_nxt   = 4'd0;
                state_nxt = S_STRD;
              end
              KK_LDR: begin
                cnt_nxt   = 4'd0;
                state_nxt = S_LDRD;
              end
              default: begin
                bad_nxt = 1'b1;
                pc_nxt  = pc_r;
              end
            endcase
          end
        endcase
      end
      S_WRX: begin
        r_addr    = op_x;
        r_we      = 1'b1;
        r_wd      = xval_r;
        state_nxt = S_DONE;
      end
      S_DMRD: begin
        if (cnt_r == op_n) begin
          r_addr    = REG_VF;
          r_we      = 1'b1;
          r_wd      = {7'b0, hit_r};
          state_nxt = S_DONE;
        end else begin
          m_addr    = i_r[11:0] + {8'b0, cnt_r};
          state_nxt = S_DBITS;
        end
      end
      S_DBITS: begin
        bits_nxt  = mq_r;
        col_nxt   = 4'd0;
        state_nxt = S_DPIX;
      end
      S_DPIX: begin
        if (col_r[3]) begin
          cnt_nxt   = cnt_r + 4'd1;
          state_nxt = S_DMRD;
        end else if (pix_on) begin
          state_nxt = S_DPWR;
        end else begin
          col_nxt = col_r + 4'd1;
        end
      end
      S_DPWR: begin
        // row read issued in the previous cycle is in fq_r
        hit_nxt   = hit_r | fq_r[paddr[5:0]];
        f_we      = 1'b1;
        col_nxt   = col_r + 4'd1;
        state_nxt = S_DPIX;
      end
      S_BCD: begin
        m_we   = 1'b1;
        m_addr = i_r[11:0] + {8'b0, cnt_r};
        case (cnt_r[1:0])
          2'd0:    m_wd = {6'b0, bcd_h};
          2'd1:    m_wd = {4'b0, bcd_t};
          default: m_wd = bcd_o;
        endcase
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd2) state_nxt = S_DONE;
      end
      S_STRD: begin
        r_addr    = cnt_r;
        state_nxt = S_STWR;
      end
      S_STWR: begin
        m_we   = 1'b1;
        m_addr = i_r[11:0] + {8'b0, cnt_r};
        m_wd   = rq_r;
        if (cnt_r == op_x) begin
          i_nxt     = i_r + {12'b0, op_x} + 16'd1;
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + 4'd1;
          state_nxt = S_STRD;
        end
      end
      S_LDRD: begin
        m_addr    = i_r[11:0] + {8'b0, cnt_r};
        state_nxt = S_LDWR;
      end
      S_LDWR: begin
        r_addr = cnt_r;
        r_we   = 1'b1;
        r_wd   = mq_r;
        if (cnt_r == op_x) begin
          i_nxt     = i_r + {12'b0, op_x} + 16'd1;
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + 4'd1;
          state_nxt = S_LDRD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          dt_nxt        = dt_tick;
          st_nxt        = st_tick;
          tick_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          out_pc_nxt    = pc_r;
          out_pix_nxt   = pix_r;
          out_draw_nxt  = draw_r;
          out_snd_nxt   = (st_tick != 8'd0);
          out_wait_nxt  = wait_r;
          out_bad_nxt   = bad_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // program memory, contents undefined until written
  always_ff @(posedge clk) begin
    if (m_we) mmem[m_addr] <= m_wd;
    mq_r <= mmem[m_addr];
  end

  // register file, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (r_we) rmem[r_addr] <= r_wd;
    rq_r <= rvalid_r[r_addr] ? rmem[r_addr] : 8'd0;
  end

  // frame buffer rows, a cleared row reads as zero
  always_ff @(posedge clk) begin
    if (f_we) fmem[f_row] <= f_wd;
    fq_r <= fvalid_r[f_row] ? fmem[f_row] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rvalid_r    <= '0;
      fvalid_r    <= '0;
      pc_r        <= START_ADDRESS;
      i_r         <= '0;
      sp_r        <= '0;
      dt_r        <= '0;
      st_r        <= '0;
      tick_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < STACK_DEPTH; s++) stack_r[s] <= '0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      i_r         <= i_nxt;
      sp_r        <= sp_nxt;
      dt_r        <= dt_nxt;
      st_r        <= st_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
      if (r_we) rvalid_r[r_addr] <= 1'b1;
      if (f_clr) fvalid_r <= '0;
      else if (f_we) fvalid_r[f_row] <= 1'b1;
      if (stk_we) stack_r[sp_r] <= pc_r;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    addr_r     <= addr_nxt;
    keys_r     <= keys_nxt;
    rnd_r      <= rnd_nxt;
    op_r       <= op_nxt;
    vx_r       <= vx_nxt;
    vy_r       <= vy_nxt;
    xval_r     <= xval_nxt;
    cnt_r      <= cnt_nxt;
    col_r      <= col_nxt;
    bits_r     <= bits_nxt;
    hit_r      <= hit_nxt;
    pix_r      <= pix_nxt;
    draw_r     <= draw_nxt;
    wait_r     <= wait_nxt;
    bad_r      <= bad_nxt;
    out_pc_r   <= out_pc_nxt;
    out_pix_r  <= out_pix_nxt;
    out_draw_r <= out_draw_nxt;
    out_snd_r  <= out_snd_nxt;
    out_wait_r <= out_wait_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_prog_counter = out_pc_r;
  assign out_pixel        = out_pix_r;
  assign out_draw_flag    = out_draw_r;
  assign out_sound_on     = out_snd_r;
  assign out_waiting_key  = out_wait_r;
  assign out_bad_opcode   = out_bad_r;

  // a step only touches pc in the execute cycle
  a_pc_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EXEC) |=> $stable(pc_r))
    else $error("pc changed outside execute");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state not one-hot");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside done");

  a_wait_no_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && wait_r) |-> !tick_r)
    else $error("timers tick during key wait");

  // func_r feeds only debug visibility of the accepted transaction kind
  a_func_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> $stable(func_r))
    else $error("transaction kind changed while busy");

endmodule
`default_nettype wire

[tb/tb_chip8_instruction_core_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chip8_instruction_core_top
// Self-checking bench for the chip-8 instruction core. Memory bytes are
// loaded before anything fetches or reads them, then directed and random
// instructions are placed at pc and executed one at a time, mixed with pixel
// reads, memory loads and unused function codes. A shadow machine predicts
// every transaction's result.
// ----------------------------------------------------------------------------
module tb_chip8_instruction_core_top;
  import c8ic_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int DRAIN_CYCLES = 600;
  localparam int ITEM_COUNT   = 1350;

  typedef struct packed {
    func_t       func;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [15:0] keys;
    logic [7:0]  rnd;
  } core_req_t;

  typedef struct packed {
    logic [11:0] pc;
    logic        pixel;
    logic        drawn;
    logic        sound;
    logic        waiting;
    logic        bad;
  } core_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = '0;
  logic [11:0] in_addr = '0;
  logic [7:0]  in_data = '0;
  logic [15:0] in_keys = '0;
  logic [7:0]  in_random = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_prog_counter;
  logic        out_pixel;
  logic        out_draw_flag;
  logic        out_sound_on;
  logic        out_waiting_key;
  logic        out_bad_opcode;

  chip8_instruction_core_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_addr(in_addr), .in_data(in_data), .in_keys(in_keys),
    .in_random(in_random),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_prog_counter(out_prog_counter), .out_pixel(out_pixel),
    .out_draw_flag(out_draw_flag), .out_sound_on(out_sound_on),
    .out_waiting_key(out_waiting_key), .out_bad_opcode(out_bad_opcode)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow machine state
  logic [7:0]  sh_mem [MEM_DEPTH];
  logic        sh_wr  [MEM_DEPTH];
  logic        sh_fb  [SCREEN_PIXELS];
  logic [7:0]  sh_v   [16];
  logic [11:0] sh_stk [STACK_DEPTH];
  logic [3:0]  sh_sp;
  logic [11:0] sh_pc;
  logic [15:0] sh_idx;
  logic [7:0]  sh_dt;
  logic [7:0]  sh_st;

  core_req_t pending_reqs[$];
  core_rsp_t expected_rsps[$];
  int        n_queued = 0;
  int        n_taken = 0;
  int        n_errors = 0;
  int        cycle = 0;

  function automatic logic quiet_window();
    return cycle >= 1500 && cycle < 4500;
  endfunction

  task automatic run_core(input core_req_t it, output core_rsp_t r);
    logic [15:0] op;
    logic [11:0] cur, nxt, ma;
    logic [3:0]  x, y, n, kidx;
    logic [7:0]  kk, vx, vy, b;
    logic [8:0]  sum;
    logic [16:0] s;
    logic        tick, hit;
    int          a;
    r = '0;
    case (it.func)
      FUNC_LOAD: sh_mem[it.addr] = it.data;
      FUNC_READ: if (it.addr < SCREEN_PIXELS) r.pixel = sh_fb[it.addr];
      FUNC_STEP: begin
        cur = sh_pc;
        op = {sh_mem[cur], sh_mem[cur + 12'd1]};
        x = op[11:8]; y = op[7:4]; n = op[3:0]; kk = op[7:0];
        vx = sh_v[x]; vy = sh_v[y];
        nxt = cur + 12'd2;
        tick = 1'b1;
        case (op[15:12])
          GRP_SYS: begin
            if (op == OP_CLS) begin
              foreach (sh_fb[i]) sh_fb[i] = 1'b0;
              r.drawn = 1'b1;
            end else if (op == OP_RET) begin
              sh_sp = sh_sp - 4'd1;
              nxt = sh_stk[sh_sp] + 12'd2;
            end else begin
              r.bad = 1'b1; nxt = cur;
            end
          end
          GRP_JP:   nxt = op[11:0];
          GRP_CALL: begin
            sh_stk[sh_sp] = cur;
            sh_sp = sh_sp + 4'd1;
            nxt = op[11:0];
          end
          GRP_SE:   if (vx == kk) nxt = cur + 12'd4;
          GRP_SNE:  if (vx != kk) nxt = cur + 12'd4;
          GRP_SER:  if (vx == vy) nxt = cur + 12'd4;
          GRP_LD:   sh_v[x] = kk;
          GRP_ADD:  sh_v[x] = vx + kk;
          GRP_ALU: begin
            case (n)
              ALU_LD:  sh_v[x] = vy;
              ALU_OR:  sh_v[x] = vx | vy;
              ALU_AND: sh_v[x] = vx & vy;
              ALU_XOR: sh_v[x] = vx ^ vy;
              ALU_ADD: begin
                sum = vx + vy;
                sh_v[REG_VF] = {7'd0, sum[8]};
                sh_v[x] = sum[7:0];
              end
              ALU_SUB: begin
                sh_v[REG_VF] = (vy > vx) ? 8'd0 : 8'd1;
                sh_v[x] = vx - vy;
              end
              ALU_SHR: begin
                sh_v[REG_VF] = {7'd0, vx[0]};
                sh_v[x] = vx >> 1;
              end
              ALU_SBN: begin
                sh_v[REG_VF] = (vx > vy) ? 8'd0 : 8'd1;
                sh_v[x] = vy - vx;
              end
              ALU_SHL: begin
                sh_v[REG_VF] = {7'd0, vx[7]};
                sh_v[x] = vx << 1;
              end
              default: begin r.bad = 1'b1; nxt = cur; end
            endcase
          end
          GRP_SNER: if (vx != vy) nxt = cur + 12'd4;
          GRP_LDI:  sh_idx = {4'd0, op[11:0]};
          GRP_JPV0: nxt = {4'd0, sh_v[REG_V0]} + op[11:0];
          GRP_RND:  sh_v[x] = it.rnd & kk;
          GRP_DRW: begin
            hit = 1'b0;
            for (int row = 0; row < n; row++) begin
              ma = sh_idx[11:0] + 12'(row);
              b = sh_mem[ma];
              for (int col = 0; col < 8; col++) begin
                if (b[7-col]) begin
                  a = int'(vx) + col + (int'(vy) + row) * SCREEN_WIDTH;
                  if (a < SCREEN_PIXELS) begin
                    if (sh_fb[a]) hit = 1'b1;
                    sh_fb[a] = ~sh_fb[a];
                  end
                end
              end
            end
            sh_v[REG_VF] = {7'd0, hit};
            r.drawn = 1'b1;
          end
          GRP_KEY: begin
            if (kk == KK_SKP) begin
              if (vx < 16 && it.keys[vx[3:0]]) nxt = cur + 12'd4;
            end else if (kk == KK_SKNP) begin
              if (!(vx < 16 && it.keys[vx[3:0]])) nxt = cur + 12'd4;
            end else begin
              r.bad = 1'b1; nxt = cur;
            end
          end
          default: begin
            case (kk)
              KK_LDDT: sh_v[x] = sh_dt;
              KK_WKEY: begin
                if (it.keys == 16'd0) begin
                  r.waiting = 1'b1; nxt = cur; tick = 1'b0;
                end else begin
                  kidx = 4'd0;
                  for (int k = 15; k >= 0; k--) if (it.keys[k]) kidx = 4'(k);
                  sh_v[x] = {4'd0, kidx};
                end
              end
              KK_SDT: sh_dt = vx;
              KK_SST: sh_st = vx;
              KK_ADDI: begin
                s = sh_idx + vx;
                sh_v[REG_VF] = (s > 17'hFFF) ? 8'd1 : 8'd0;
                sh_idx = s[15:0];
              end
              KK_FONT: sh_idx = vx * 16'd5;
              KK_BCD: begin
                sh_mem[sh_idx[11:0]] = vx / 100;
                sh_mem[sh_idx[11:0] + 12'd1] = (vx / 10) % 10;
                sh_mem[sh_idx[11:0] + 12'd2] = vx % 10;
              end
              KK_STR: begin
                for (int i = 0; i <= x; i++) sh_mem[sh_idx[11:0] + 12'(i)] = sh_v[i];
                sh_idx = sh_idx + x + 16'd1;
              end
              KK_LDR: begin
                for (int i = 0; i <= x; i++) sh_v[i] = sh_mem[sh_idx[11:0] + 12'(i)];
                sh_idx = sh_idx + x + 16'd1;
              end
              default: begin r.bad = 1'b1; nxt = cur; end
            endcase
          end
        endcase
        sh_pc = nxt;
        if (tick) begin
          if (sh_dt != 0) sh_dt = sh_dt - 8'd1;
          if (sh_st != 0) sh_st = sh_st - 8'd1;
        end
      end
      default: ;
    endcase
    r.pc = sh_pc;
    r.sound = (sh_st != 0);
  endtask

  initial begin
    foreach (sh_mem[i]) sh_mem[i] = 8'd0;
    foreach (sh_wr[i]) sh_wr[i] = 1'b0;
    foreach (sh_fb[i]) sh_fb[i] = 1'b0;
    foreach (sh_v[i]) sh_v[i] = 8'd0;
    foreach (sh_stk[i]) sh_stk[i] = 12'd0;
    sh_sp = '0;
    sh_pc = START_ADDRESS;
    sh_idx = '0;
    sh_dt = '0;
    sh_st = '0;
  end

  // driver: predicts on each accepted transaction
  always @(posedge clk) begin
    core_req_t nx;
    core_rsp_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        run_core(core_req_t'({func_t'(in_func), in_addr, in_data, in_keys, in_random}), r);
        expected_rsps.push_back(r);
        n_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && (quiet_window() || $urandom_range(0, 99) >= 22)) begin
          nx = pending_reqs.pop_front();
          in_valid  <= 1'b1;
          in_func   <= nx.func;
          in_addr   <= nx.addr;
          in_data   <= nx.data;
          in_keys   <= nx.keys;
          in_random <= nx.rnd;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: result channel stall and checking
  always @(posedge clk) begin
    core_rsp_t got, want;
    cycle <= cycle + 1;
    if (cycle > LIMIT_CYCLES) begin
      $display("[chip8_instruction_core_top] ERROR");
      $finish;
    end else if (rst_n) begin
      out_stall <= !quiet_window() && ($urandom_range(0, 99) < 22);
      if (out_valid && !out_stall) begin
        got = '{out_prog_counter, out_pixel, out_draw_flag, out_sound_on,
                out_waiting_key, out_bad_opcode};
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected transaction pc=%h", $time, out_prog_counter);
          n_errors++;
        end else begin
          want = expected_rsps.pop_front();
          if (got.pc !== want.pc)
            $display("%0t: pc exp %h got %h", $time, want.pc, got.pc);
          if (got.pixel !== want.pixel)
            $display("%0t: pixel exp %b got %b", $time, want.pixel, got.pixel);
          if (got.drawn !== want.drawn)
            $display("%0t: draw_flag exp %b got %b", $time, want.drawn, got.drawn);
          if (got.sound !== want.sound)
            $display("%0t: sound_on exp %b got %b", $time, want.sound, got.sound);
          if (got.waiting !== want.waiting)
            $display("%0t: waiting_key exp %b got %b", $time, want.waiting, got.waiting);
          if (got.bad !== want.bad)
            $display("%0t: bad_opcode exp %b got %b", $time, want.bad, got.bad);
          if (got !== want) n_errors++;
        end
      end
    end
  end

  task automatic queue_req(input func_t f, input logic [11:0] a, input logic [7:0] d,
                           input logic [15:0] k, input logic [7:0] rv);
    if (f == FUNC_LOAD) sh_wr[a] = 1'b1;
    pending_reqs.push_back('{f, a, d, k, rv});
    n_queued++;
  endtask

  task automatic wait_settled();
    while (n_taken != n_queued) @(posedge clk);
  endtask

  // load a random byte where nothing was loaded yet
  task automatic ensure_written(input logic [11:0] a);
    if (!sh_wr[a]) queue_req(FUNC_LOAD, a, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // sprite and register loads read up to sixteen bytes from the index
  task automatic cover_reads(input logic [15:0] op);
    if (op[15:12] == GRP_DRW || (op[15:12] == GRP_MISC && op[7:0] == KK_LDR)) begin
      for (int i = 0; i < 16; i++) ensure_written(sh_idx[11:0] + 12'(i));
    end
  endtask

  // place an opcode at the current pc and execute it
  task automatic exec_op(input logic [15:0] op, input logic [15:0] k);
    wait_settled();
    queue_req(FUNC_LOAD, sh_pc, op[15:8], 16'($urandom), 8'($urandom));
    queue_req(FUNC_LOAD, sh_pc + 12'd1, op[7:0], 16'($urandom), 8'($urandom));
    cover_reads(op);
    queue_req(FUNC_STEP, 12'($urandom), 8'($urandom), k, 8'($urandom));
  endtask

  // execute whatever sits at the current pc
  task automatic step_here(input logic [15:0] k);
    logic [15:0] op;
    wait_settled();
    ensure_written(sh_pc);
    ensure_written(sh_pc + 12'd1);
    wait_settled();
    op = {sh_mem[sh_pc], sh_mem[sh_pc + 12'd1]};
    cover_reads(op);
    queue_req(FUNC_STEP, 12'($urandom), 8'($urandom), k, 8'($urandom));
  endtask

  function automatic logic [15:0] pick_op();
    logic [3:0] g, x, y;
    logic [7:0] kk;
    logic [7:0] misc_kk [11] = '{KK_LDDT, KK_WKEY, KK_SDT, KK_SST, KK_ADDI, KK_FONT,
                                 KK_BCD, KK_STR, KK_LDR, KK_SKP, KK_SKNP};
    logic [3:0] alu_n [9] = '{ALU_LD, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB,
                              ALU_SHR, ALU_SBN, ALU_SHL};
    g = 4'($urandom);
    x = 4'($urandom);
    y = 4'($urandom);
    kk = 8'($urandom);
    case (g)
      GRP_SYS: begin
        case ($urandom_range(0, 3))
          0, 1: return OP_CLS;
          2: return OP_RET;
          default: return {g, 4'(x), kk};
        endcase
      end
      GRP_ALU: if ($urandom_range(0, 9) != 0) kk[3:0] = alu_n[$urandom_range(0, 8)];
      GRP_KEY: if ($urandom_range(0, 9) != 0) kk = misc_kk[$urandom_range(9, 10)];
      GRP_MISC: if ($urandom_range(0, 9) != 0) kk = misc_kk[$urandom_range(0, 8)];
      GRP_SE, GRP_SNE: if ($urandom_range(0, 1)) kk = sh_v[x];
      default: ;
    endcase
    return {g, x, kk};
  endfunction

  function automatic logic [15:0] pick_keys();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'd1 << $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    exec_op(16'h00EE, 16'h0000);                      // return from empty stack
    exec_op(16'h0123, 16'hFFFF);                      // unknown system call
    exec_op({GRP_LD, 4'h3, 8'hFF}, 16'h0000);
    exec_op({GRP_MISC, 4'h3, KK_SST}, 16'h0000);     // sound timer running
    exec_op({GRP_LDI, 12'hFFE}, 16'h0000);
    exec_op({GRP_MISC, 4'h3, KK_BCD}, 16'h0000);     // bcd of 255, wraps memory
    exec_op({GRP_MISC, 4'h3, KK_ADDI}, 16'h0000);    // index carry past 0xfff
    exec_op({GRP_MISC, 4'h0, KK_WKEY}, 16'h0000);    // key wait, nothing pressed
    exec_op({GRP_MISC, 4'h0, KK_WKEY}, 16'h8000);
    exec_op({GRP_KEY, 4'h3, KK_SKP}, 16'hFFFF);      // key value out of range
    exec_op({GRP_KEY, 4'h3, KK_SKNP}, 16'hFFFF);
    exec_op({GRP_ALU, 4'h1, 4'h3, 4'hF}, 16'h0000);  // bad alu code
    exec_op({GRP_KEY, 4'h1, 8'h00}, 16'h0000);
    exec_op({GRP_MISC, 4'h1, 8'hFF}, 16'h0000);
    exec_op({GRP_LD, 4'h4, 8'd60}, 16'h0000);
    exec_op({GRP_LD, 4'h5, 8'd31}, 16'h0000);
    exec_op({GRP_LDI, 12'h000}, 16'h0000);
    exec_op({GRP_DRW, 4'h4, 4'h5, 4'hF}, 16'h0000);  // sprite off the edges
    exec_op({GRP_DRW, 4'h4, 4'h5, 4'hF}, 16'h0000);  // same again, collides
    exec_op({GRP_MISC, 4'hF, KK_STR}, 16'h0000);
    exec_op(OP_CLS, 16'h0000);
    wait_settled();
    queue_req(FUNC_READ, 12'hFFF, 8'h00, 16'h0000, 8'h00);
    queue_req(FUNC_NONE, 12'hABC, 8'hFF, 16'hFFFF, 8'hFF);

    while (n_queued < ITEM_COUNT) begin
      if ($urandom_range(0, 99) < 80) begin
        exec_op(pick_op(), pick_keys());
      end else begin
        case ($urandom_range(0, 4))
          0, 1: queue_req(FUNC_READ, 12'($urandom_range(0, 2100)), 8'($urandom),
                          16'($urandom), 8'($urandom));
          2: step_here(pick_keys());
          3: queue_req(FUNC_LOAD, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
          default: queue_req(FUNC_NONE, 12'($urandom), 8'($urandom), 16'($urandom),
                             8'($urandom));
        endcase
      end
    end

    wait_settled();
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("[chip8_instruction_core_top] OK");
    end else begin
      $display("[chip8_instruction_core_top] ERROR");
    end
    $finish;
  end

endmodule
